>>> rtl/core/ntc_pkg.sv
// ----------------------------------------------------------------------------
// NTC lookup package
// Shared widths, codes, transaction structs and the temperature table
// for the NTC thermistor temperature lookup.
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam int TABLE_ENTRIES = 108;
    localparam int ADC_BITS      = 12;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int VREF_W  = 13;
    localparam int DIVR_W  = 20;
    localparam int MV_W    = VREF_W;
    localparam int PROD_W  = MV_W + DIVR_W;
    localparam int RES_W   = 32;
    localparam int R10_W   = RES_W + 4;
    localparam int ROM_W   = 22;
    localparam int TEMP_W  = 9;
    localparam int DIV_STEPS = PROD_W;
    localparam int DCNT_W  = $clog2(DIV_STEPS);

    localparam logic signed [TEMP_W-1:0] TEMP_NO_MATCH  = -9'sd50;
    localparam logic signed [TEMP_W-1:0] TEMP_ADC_ERROR = -9'sd200;

    // Configuration register indexes
    localparam logic CFG_VREF = 1'b0;
    localparam logic CFG_DIVR = 1'b1;

    typedef enum logic [1:0] {
        STAT_FOUND     = 2'd0,
        STAT_NO_MATCH  = 2'd1,
        STAT_ADC_ERROR = 2'd2,
        STAT_RANGE     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_PROD,
        ST_DIV,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [MV_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic                     done;
        logic                     found;
        logic signed [TEMP_W-1:0] temp;
    } t_scan_rsp;

    // One table row: temperature, nominal, min and max in tenths of an ohm
    typedef struct packed {
        logic signed [TEMP_W-1:0] deg;
        logic [ROM_W-1:0]         nom;
        logic [ROM_W-1:0]         lo;
        logic [ROM_W-1:0]         hi;
    } t_row;

    localparam t_row ROW_TABLE [TABLE_ENTRIES] = '{
        '{-9'sd47, 22'd2354300, 22'd1937500, 22'd2771100},
        '{-9'sd46, 22'd2199100, 22'd1814900, 22'd2583400},
        '{-9'sd45, 22'd2055200, 22'd1700800, 22'd2409600},
        '{-9'sd44, 22'd1921600, 22'd1594600, 22'd2248600},
        '{-9'sd43, 22'd1797500, 22'd1495700, 22'd2099400},
        '{-9'sd42, 22'd1682300, 22'd1403500, 22'd1961000},
        '{-9'sd41, 22'd1575200, 22'd1317600, 22'd1832700},
        '{-9'sd40, 22'd1475600, 22'd1237600, 22'd1713600},
        '{-9'sd39, 22'd1382900, 22'd1162800, 22'd1603000},
        '{-9'sd38, 22'd1296600, 22'd1093100, 22'd1500200},
        '{-9'sd37, 22'd1216300, 22'd1028000, 22'd1404700},
        '{-9'sd36, 22'd1141500, 22'd967120,  22'd1315800},
        '{-9'sd35, 22'd1071700, 22'd910260,  22'd1233100},
        '{-9'sd34, 22'd1006600, 22'd857080,  22'd1156200},
        '{-9'sd33, 22'd945910,  22'd807340,  22'd1084500},
        '{-9'sd32, 22'd889240,  22'd760790,  22'd1017700},
        '{-9'sd31, 22'd836310,  22'd717210,  22'd955420},
        '{-9'sd30, 22'd786870,  22'd676390,  22'd897340},
        '{-9'sd29, 22'd739950,  22'd637540,  22'd842360},
        '{-9'sd28, 22'd696150,  22'd601180,  22'd791120},
        '{-9'sd27, 22'd655240,  22'd567130,  22'd743340},
        '{-9'sd26, 22'd617000,  22'd535240,  22'd698760},
        '{-9'sd25, 22'd581260,  22'd505350,  22'd657160},
        '{-9'sd24, 22'd547820,  22'd477330,  22'd618300},
        '{-9'sd23, 22'd516520,  22'd451050,  22'd582000},
        '{-9'sd22, 22'd487220,  22'd426380,  22'd548070},
        '{-9'sd21, 22'd459780,  22'd403220,  22'd516340},
        '{-9'sd20, 22'd434060,  22'd381470,  22'd486650},
        '{-9'sd19, 22'd410450,  22'd361480,  22'd459420},
        '{-9'sd18, 22'd388260,  22'd342650,  22'd433880},
        '{-9'sd17, 22'd367410,  22'd324910,  22'd409910},
        '{-9'sd16, 22'd347810,  22'd308200,  22'd387410},
        '{-9'sd15, 22'd329370,  22'd292450,  22'd366290},
        '{-9'sd14, 22'd312020,  22'd277600,  22'd346440},
        '{-9'sd13, 22'd295690,  22'd263590,  22'd327790},
        '{-9'sd12, 22'd280310,  22'd250370,  22'd310250},
        '{-9'sd11, 22'd265830,  22'd237890,  22'd293760},
        '{-9'sd10, 22'd252170,  22'd226110,  22'd278240},
        '{-9'sd9,  22'd239100,  22'd214790,  22'd263410},
        '{-9'sd8,  22'd226790,  22'd204110,  22'd249460},
        '{-9'sd7,  22'd215180,  22'd194030,  22'd236330},
        '{-9'sd6,  22'd204240,  22'd184510,  22'd223970},
        '{-9'sd5,  22'd193920,  22'd175510,  22'd212340},
        '{-9'sd4,  22'd184190,  22'd167000,  22'd201380},
        '{-9'sd3,  22'd175000,  22'd158960,  22'd191050},
        '{-9'sd2,  22'd166330,  22'd151350,  22'd181310},
        '{-9'sd1,  22'd158140,  22'd144150,  22'd172130},
        '{9'sd0,   22'd150400,  22'd137330,  22'd163470},
        '{9'sd1,   22'd143050,  22'd130840,  22'd155250},
        '{9'sd2,   22'd136100,  22'd124700,  22'd147490},
        '{9'sd3,   22'd129530,  22'd118880,  22'd140170},
        '{9'sd4,   22'd123310,  22'd113370,  22'd133250},
        '{9'sd5,   22'd117430,  22'd108150,  22'd126720},
        '{9'sd6,   22'd111870,  22'd103190,  22'd120550},
        '{9'sd7,   22'd106600,  22'd98497,   22'd114710},
        '{9'sd8,   22'd101610,  22'd94041,   22'd109190},
        '{9'sd9,   22'd96889,   22'd89813,   22'd103970},
        '{9'sd10,  22'd92411,   22'd85799,   22'd99024},
        '{9'sd11,  22'd88177,   22'd81997,   22'd94357},
        '{9'sd12,  22'd84161,   22'd78386,   22'd89937},
        '{9'sd13,  22'd80352,   22'd74955,   22'd85749},
        '{9'sd14,  22'd76736,   22'd71692,   22'd81779},
        '{9'sd15,  22'd73303,   22'd68590,   22'd78016},
        '{9'sd16,  22'd70044,   22'd65640,   22'd74447},
        '{9'sd17,  22'd66947,   22'd62833,   22'd71062},
        '{9'sd18,  22'd64005,   22'd60161,   22'd67849},
        '{9'sd19,  22'd61209,   22'd57618,   22'd64800},
        '{9'sd20,  22'd58550,   22'd55197,   22'd61904},
        '{9'sd21,  22'd56003,   22'd52872,   22'd59134},
        '{9'sd22,  22'd53581,   22'd50658,   22'd56503},
        '{9'sd23,  22'd51277,   22'd48550,   22'd54004},
        '{9'sd24,  22'd49086,   22'd46541,   22'd51630},
        '{9'sd25,  22'd47000,   22'd44650,   22'd49350},
        '{9'sd26,  22'd44962,   22'd42632,   22'd47292},
        '{9'sd27,  22'd43025,   22'd40738,   22'd45312},
        '{9'sd28,  22'd41184,   22'd38941,   22'd43426},
        '{9'sd29,  22'd39433,   22'd37234,   22'd41631},
        '{9'sd30,  22'd37767,   22'd35612,   22'd39922},
        '{9'sd31,  22'd36219,   22'd34106,   22'd38332},
        '{9'sd32,  22'd34744,   22'd32672,   22'd36815},
        '{9'sd33,  22'd33337,   22'd31307,   22'd35366},
        '{9'sd34,  22'd31994,   22'd30006,   22'd33982},
        '{9'sd35,  22'd30713,   22'd28766,   22'd32660},
        '{9'sd36,  22'd29490,   22'd27584,   22'd31396},
        '{9'sd37,  22'd28322,   22'd26457,   22'd30188},
        '{9'sd38,  22'd27207,   22'd25382,   22'd29033},
        '{9'sd39,  22'd26142,   22'd24356,   22'd27928},
        '{9'sd40,  22'd25124,   22'd23377,   22'd26872},
        '{9'sd41,  22'd24150,   22'd22442,   22'd25859},
        '{9'sd42,  22'd23220,   22'd21549,   22'd24890},
        '{9'sd43,  22'd22329,   22'd20697,   22'd23962},
        '{9'sd44,  22'd21478,   22'd19882,   22'd23074},
        '{9'sd45,  22'd20664,   22'd19104,   22'd22224},
        '{9'sd46,  22'd19885,   22'd18361,   22'd21409},
        '{9'sd47,  22'd19139,   22'd17650,   22'd20629},
        '{9'sd48,  22'd18426,   22'd16971,   22'd19881},
        '{9'sd49,  22'd17742,   22'd16321,   22'd19164},
        '{9'sd50,  22'd17088,   22'd15700,   22'd18476},
        '{9'sd51,  22'd16456,   22'd15101,   22'd17812},
        '{9'sd52,  22'd15852,   22'd14528,   22'd17175},
        '{9'sd53,  22'd15272,   22'd13980,   22'd16565},
        '{9'sd54,  22'd14718,   22'd13456,   22'd15979},
        '{9'sd55,  22'd14186,   22'd12954,   22'd15418},
        '{9'sd56,  22'd13676,   22'd12474,   22'd14879},
        '{9'sd57,  22'd13188,   22'd12014,   22'd14362},
        '{9'sd58,  22'd12719,   22'd11573,   22'd13865},
        '{9'sd59,  22'd12270,   22'd11151,   22'd13389},
        '{9'sd60,  22'd11839,   22'd10747,   22'd12931}
    };

endpackage

>>> rtl/core/ntc_div.sv
// ----------------------------------------------------------------------------
// NTC restoring divider
// Restoring subtract unit that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntc_div
    import ntc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [MV_W-1:0]   r_rem;
    logic [PROD_W-1:0] r_quot;
    logic [MV_W-1:0]   r_dvs;

    logic [MV_W:0]     shifted;
    logic [MV_W+1:0]   diff;
    logic              borrow;

    // Trial subtract of the divisor from the shifted partial remainder
    assign shifted = {r_rem, r_quot[PROD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_dvs};
    assign borrow  = diff[MV_W+1];

    // Control: start, count steps, pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quot <= i_req.dividend;
            r_dvs  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= borrow ? shifted[MV_W-1:0] : diff[MV_W-1:0];
            r_quot <= {r_quot[PROD_W-2:0], ~borrow};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

>>> rtl/core/ntc_scan.sv
// ----------------------------------------------------------------------------
// NTC table scanner
// Walks the temperature table one row per cycle and keeps the closest
// nominal match among rows whose window holds the resistance.
// ----------------------------------------------------------------------------
module ntc_scan
    import ntc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RES_W-1:0] i_res,
    output t_scan_rsp        o_rsp
);

    logic                     r_busy;
    logic                     r_done;
    logic [IDX_W-1:0]         r_idx;
    logic [R10_W-1:0]         r_r10;
    logic                     r_found;
    logic [ROM_W-1:0]         r_best;
    logic signed [TEMP_W-1:0] r_temp;

    t_row                     row;
    logic                     hit;
    logic [ROM_W-1:0]         r10_lo;
    logic [ROM_W-1:0]         nom_diff;
    logic                     take;
    logic                     stop;

    // Compare the current row against the scaled resistance
    always_comb begin
        row      = ROW_TABLE[r_idx];
        r10_lo   = r_r10[ROM_W-1:0];
        hit      = (r_r10 >= R10_W'(row.lo)) && (r_r10 <= R10_W'(row.hi));
        nom_diff = (row.nom > r10_lo) ? (row.nom - r10_lo) : (r10_lo - row.nom);
        take     = hit && (!r_found || nom_diff < r_best);
        stop     = (!hit && r_found) || (r_idx == IDX_W'(TABLE_ENTRIES - 1));
    end

    // Control: walk the rows until a miss after a hit or the last row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && stop) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: row index, scaled resistance and best candidate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx   <= '0;
            r_r10   <= ({4'b0000, i_res} << 3) + ({4'b0000, i_res} << 1);
            r_found <= 1'b0;
            r_best  <= '0;
            r_temp  <= TEMP_NO_MATCH;
        end else if (r_busy) begin
            r_idx <= r_idx + 1'b1;
            if (take) begin
                r_found <= 1'b1;
                r_best  <= nom_diff;
                r_temp  <= row.deg;
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.found = r_found;
    assign o_rsp.temp  = r_temp;

endmodule

>>> rtl/core/ntc_thermistor_temperature_lookup.sv
// ----------------------------------------------------------------------------
// NTC thermistor temperature lookup
// Converts one ADC sample of an NTC divider to resistance and temperature.
// ----------------------------------------------------------------------------
// One sample is taken at a time; o_stall stays high from the accepting edge
// until the result has moved into the output register. A normal sample goes
// through a scaling step, a product step, the bit-serial divider and a walk
// of one table row per cycle (up to 108, fewer when the walk ends on a miss
// after a hit), then hands off to the output register. An ADC error or a
// zero reference skips the arithmetic. The divider and the table walk take
// most of the time. The output register lets the next sample start while a
// result still waits downstream. Configuration writes are always accepted;
// they take effect at once, so to apply to the next sample, write while idle.
module ntc_thermistor_temperature_lookup
    import ntc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Sample channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [ADC_BITS-1:0]      i_sample_raw,
    input  logic                     i_adc_failed,
    // Result channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [TEMP_W-1:0] o_temperature_c,
    output logic [RES_W-1:0]         o_resistance_ohms,
    output logic [1:0]               o_status,
    // Configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_index,
    input  logic [DIVR_W-1:0]        i_cfg_data
);

    t_state                   r_state, n_state;
    logic [VREF_W-1:0]        r_vref;
    logic [DIVR_W-1:0]        r_divr;
    logic [ADC_BITS-1:0]      r_raw, n_raw;
    logic [MV_W-1:0]          r_mv, n_mv;
    logic signed [TEMP_W-1:0] r_temp, n_temp;
    logic [RES_W-1:0]         r_res, n_res;
    t_status                  r_stat, n_stat;
    logic                     r_out_valid, n_out_valid;
    logic signed [TEMP_W-1:0] r_out_temp, n_out_temp;
    logic [RES_W-1:0]         r_out_res, n_out_res;
    t_status                  r_out_stat, n_out_stat;

    logic [ADC_BITS+VREF_W-1:0] scale_prod;
    logic [RES_W-1:0]           res_sat;
    logic                       accept;
    logic                       out_free;
    t_div_req                   div_req;
    t_div_rsp                   div_rsp;
    logic                       scan_start;
    t_scan_rsp                  scan_rsp;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);

    // Scale the sample to millivolts and saturate the quotient
    assign scale_prod = r_raw * r_vref;
    assign res_sat    = div_rsp.quot[PROD_W-1] ? '1 : div_rsp.quot[RES_W-1:0];

    // Divider request: mv * divider over vref - mv
    assign div_req.start    = (r_state == ST_PROD);
    assign div_req.dividend = r_mv * r_divr;
    assign div_req.divisor  = r_vref - r_mv;

    assign scan_start = (r_state == ST_DIV) && div_rsp.done;

    ntc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ntc_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_res   (res_sat),
        .o_rsp   (scan_rsp)
    );

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vref <= VREF_W'(3300);
            r_divr <= DIVR_W'(4700);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_VREF: r_vref <= i_cfg_data[VREF_W-1:0];
                CFG_DIVR: r_divr <= i_cfg_data;
                default:  r_divr <= r_divr;
            endcase
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_raw      <= n_raw;
        r_mv       <= n_mv;
        r_temp     <= n_temp;
        r_res      <= n_res;
        r_stat     <= n_stat;
        r_out_temp <= n_out_temp;
        r_out_res  <= n_out_res;
        r_out_stat <= n_out_stat;
    end

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_raw       = r_raw;
        n_mv        = r_mv;
        n_temp      = r_temp;
        n_res       = r_res;
        n_stat      = r_stat;
        n_out_valid = r_out_valid;
        n_out_temp  = r_out_temp;
        n_out_res   = r_out_res;
        n_out_stat  = r_out_stat;

        // Drop the output transaction once it is taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_raw = i_sample_raw;
                    if (i_adc_failed) begin
                        n_temp  = TEMP_ADC_ERROR;
                        n_res   = '0;
                        n_stat  = STAT_ADC_ERROR;
                        n_state = ST_DONE;
                    end else if (r_vref == '0) begin
                        n_temp  = TEMP_NO_MATCH;
                        n_res   = '1;
                        n_stat  = STAT_RANGE;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCALE;
                    end
                end
            end
            ST_SCALE: begin
                n_mv    = scale_prod[ADC_BITS+VREF_W-1:ADC_BITS];
                n_state = ST_PROD;
            end
            ST_PROD: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_res   = res_sat;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_rsp.done) begin
                    n_temp  = scan_rsp.found ? scan_rsp.temp : TEMP_NO_MATCH;
                    n_stat  = scan_rsp.found ? STAT_FOUND : STAT_NO_MATCH;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_temp  = r_temp;
                    n_out_res   = r_res;
                    n_out_stat  = r_stat;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid           = r_out_valid;
    assign o_temperature_c   = r_out_temp;
    assign o_resistance_ohms = r_out_res;
    assign o_status          = r_out_stat;

endmodule

>>> rtl/core/ntc_checker.sv
// ----------------------------------------------------------------------------
// NTC lookup port checker
// Watches the ports of the lookup block over time and flags violations.
// ----------------------------------------------------------------------------
module ntc_checker
    import ntc_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_stall,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic signed [TEMP_W-1:0] o_temperature_c,
    input logic [RES_W-1:0]         o_resistance_ohms,
    input logic [1:0]               o_status
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_resistance_ohms) && $stable(o_temperature_c))
        else $error("result transaction dropped or changed under stall");

    // Stall the sample channel right after a transaction is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("sample channel not stalled while busy");

    // ADC error results carry the error temperature and zero resistance
    a_adc_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STAT_ADC_ERROR |->
            o_temperature_c == TEMP_ADC_ERROR && o_resistance_ohms == '0)
        else $error("bad ADC error result");

    // A found result lies within the table's temperature span
    a_found_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STAT_FOUND |->
            o_temperature_c >= -9'sd47 && o_temperature_c <= 9'sd60)
        else $error("found temperature outside table");

    // Out of range results saturate the resistance
    a_range_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STAT_RANGE |->
            o_resistance_ohms == '1 && o_temperature_c == TEMP_NO_MATCH)
        else $error("bad out of range result");

endmodule

bind ntc_thermistor_temperature_lookup ntc_checker u_ntc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_temperature_c   (o_temperature_c),
    .o_resistance_ohms (o_resistance_ohms),
    .o_status          (o_status)
);
